// ===== hw/rtl/spic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spic_pkg
// Types and constants shared by the SPI controller register block: item and
// result structs, operation codes, register offsets and error codes.
// ----------------------------------------------------------------------------
package spic_pkg;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_TICK     = 3'd2,
		OP_RX_WORD  = 3'd3,
		OP_RX_START = 3'd4,
		OP_RX_END   = 3'd5
	} op_t;

	localparam logic [11:0] OFS_CTRL0  = 12'h000;
	localparam logic [11:0] OFS_CTRL1  = 12'h004;
	localparam logic [11:0] OFS_DATA   = 12'h008;
	localparam logic [11:0] OFS_STATUS = 12'h00C;
	localparam logic [11:0] OFS_MASK   = 12'h014;
	localparam logic [11:0] OFS_RAW    = 12'h018;
	localparam logic [11:0] OFS_CLEAR  = 12'h020;
	localparam logic [11:0] OFS_DMA    = 12'h024;

	localparam logic [2:0] ERR_OK          = 3'd0;
	localparam logic [2:0] ERR_UNMAPPED    = 3'd1;
	localparam logic [2:0] ERR_TX_OVERFLOW = 3'd2;
	localparam logic [2:0] ERR_RX_UNDERFLOW = 3'd3;
	localparam logic [2:0] ERR_RX_OVERFLOW = 3'd4;
	localparam logic [2:0] ERR_BAD_EVENT   = 3'd5;

	// raw interrupt value after reset: tx half empty
	localparam logic [3:0] RAW_RESET = 4'b1000;
	// bits wiped by an interrupt clear
	localparam logic [3:0] CLEAR_BITS = 4'b0011;

	typedef struct packed {
		op_t         op;
		logic [11:0] reg_offset;
		logic [15:0] word;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        tx_valid;
		logic [15:0] tx_word;
		logic [3:0]  irq_status;
		logic [2:0]  error;
	} result_t;

endpackage

// ===== hw/rtl/spi_controller_fifo_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_controller_fifo_regs
// Register side of an SPI controller with transmit and receive FIFOs.
// ----------------------------------------------------------------------------
// Takes one item (bus read, bus write, transmit tick, received word, reception
// start or end) per clock while results are drained and returns exactly one
// result for each. An item is captured in an input register, evaluated against
// the FIFO and control state by one pass of combinational logic, and lands in
// the result register when that register is free or its result is taken; a
// new item is taken every cycle as long as results are drained. The FIFO
// pointers, counts and interrupt flags update in the same cycle as the item
// moves into the result register, which lets back-to-back items see each
// other's effects.
module spi_controller_fifo_regs
	import spic_pkg::*;
#(
	parameter int FIFO_DEPTH = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW   = $clog2(FIFO_DEPTH + 1);
	localparam int SW   = PW + 2;
	localparam int HALF = FIFO_DEPTH / 2;

	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
	localparam logic [CW-1:0] HALF_C  = CW'(HALF);
	localparam logic [PW-1:0] LAST_C  = PW'(FIFO_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);

	// stage registers
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;

	// controller state
	logic [15:0]   tx_mem_q [FIFO_DEPTH];
	logic [15:0]   rx_mem_q [FIFO_DEPTH];
	logic [CW-1:0] tx_count_q, rx_count_q;
	logic [PW-1:0] tx_head_q, rx_head_q;
	logic          busy_q, pend_q, en_q;
	logic [15:0]   mask_q;
	logic [3:0]    raw_q, masked_q;

	logic advance;

	// next state
	logic [CW-1:0] n_tx_count, n_rx_count;
	logic [PW-1:0] n_tx_head, n_rx_head;
	logic          n_busy, n_pend, n_en;
	logic [15:0]   n_mask;
	logic [3:0]    n_raw, n_masked;
	logic          tx_we, rx_we, fifo_chg;
	logic [PW-1:0] tx_widx, rx_widx;
	logic [SW-1:0] tx_sum, rx_sum;
	logic [15:0]   rd, txw, status;
	logic          txv;
	logic [2:0]    err;

	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == LAST_C) ? '0 : p + 1'b1;
	endfunction

	// tail slot: head plus count, wrapped once
	assign tx_sum  = SW'(tx_head_q) + SW'(tx_count_q);
	assign rx_sum  = SW'(rx_head_q) + SW'(rx_count_q);
	assign tx_widx = (tx_sum >= DEPTH_S) ? PW'(tx_sum - DEPTH_S) : PW'(tx_sum);
	assign rx_widx = (rx_sum >= DEPTH_S) ? PW'(rx_sum - DEPTH_S) : PW'(rx_sum);

	always_comb begin
		status     = '0;
		status[0]  = (tx_count_q == '0);
		status[1]  = (tx_count_q != DEPTH_C);
		status[2]  = (rx_count_q != '0);
		status[3]  = (rx_count_q == DEPTH_C);
		status[4]  = busy_q;
	end

	always_comb begin
		n_tx_count = tx_count_q;
		n_rx_count = rx_count_q;
		n_tx_head  = tx_head_q;
		n_rx_head  = rx_head_q;
		n_busy     = busy_q;
		n_pend     = pend_q;
		n_en       = en_q;
		n_mask     = mask_q;
		n_raw      = raw_q;
		n_masked   = masked_q;
		tx_we      = 1'b0;
		rx_we      = 1'b0;
		fifo_chg   = 1'b0;
		rd         = '0;
		txw        = '0;
		txv        = 1'b0;
		err        = ERR_OK;

		unique case (item_s1.op)
			OP_READ: begin
				if (item_s1.reg_offset == OFS_DATA) begin
					if (rx_count_q == '0) begin
						err = ERR_RX_UNDERFLOW;
					end else begin
						rd         = rx_mem_q[rx_head_q];
						n_rx_head  = next_ptr(rx_head_q);
						n_rx_count = rx_count_q - 1'b1;
						fifo_chg   = 1'b1;
					end
				end else if (item_s1.reg_offset == OFS_STATUS) begin
					rd = status;
				end else if (item_s1.reg_offset == OFS_RAW) begin
					rd = {12'h000, raw_q};
				end else begin
					err = ERR_UNMAPPED;
				end
			end
			OP_WRITE: begin
				if (item_s1.reg_offset == OFS_CTRL0 || item_s1.reg_offset == OFS_DMA) begin
					// accepted, no effect
				end else if (item_s1.reg_offset == OFS_CTRL1) begin
					n_en = item_s1.word[1];
					if (item_s1.word[1] && !busy_q && tx_count_q != '0) begin
						n_busy = 1'b1;
						n_pend = 1'b1;
					end
				end else if (item_s1.reg_offset == OFS_DATA) begin
					if (tx_count_q >= DEPTH_C) begin
						err = ERR_TX_OVERFLOW;
					end else begin
						tx_we      = 1'b1;
						n_tx_count = tx_count_q + 1'b1;
						fifo_chg   = 1'b1;
						if (en_q) begin
							n_busy = 1'b1;
							n_pend = 1'b1;
						end
					end
				end else if (item_s1.reg_offset == OFS_MASK) begin
					n_mask = item_s1.word;
				end else if (item_s1.reg_offset == OFS_CLEAR) begin
					n_raw    = raw_q & ~CLEAR_BITS;
					n_masked = masked_q & ~CLEAR_BITS;
				end else begin
					err = ERR_UNMAPPED;
				end
			end
			OP_TICK: begin
				if (pend_q && en_q && tx_count_q != '0) begin
					txw        = tx_mem_q[tx_head_q];
					txv        = 1'b1;
					n_tx_head  = next_ptr(tx_head_q);
					n_tx_count = tx_count_q - 1'b1;
					fifo_chg   = 1'b1;
					if (tx_count_q == CW'(1)) begin
						n_pend = 1'b0;
						n_busy = 1'b0;
					end
				end
			end
			OP_RX_WORD: begin
				if (!en_q) begin
					err = ERR_BAD_EVENT;
				end else if (rx_count_q >= DEPTH_C) begin
					err = ERR_RX_OVERFLOW;
				end else begin
					rx_we      = 1'b1;
					n_rx_count = rx_count_q + 1'b1;
					fifo_chg   = 1'b1;
				end
			end
			OP_RX_START: begin
				if (rx_count_q >= DEPTH_C || !en_q || busy_q) begin
					err = ERR_BAD_EVENT;
				end else begin
					n_busy = 1'b1;
				end
			end
			OP_RX_END: begin
				if (!en_q || !busy_q) begin
					err = ERR_BAD_EVENT;
				end else begin
					n_busy = 1'b0;
					if (tx_count_q != '0) begin
						n_busy = 1'b1;
						n_pend = 1'b1;
					end
				end
			end
			default: begin
				// unused op codes do nothing
			end
		endcase

		// interrupt flags follow the new fill levels
		if (fifo_chg) begin
			n_raw[3] = (n_tx_count <= HALF_C);
			n_raw[2] = (n_rx_count >= HALF_C);
			n_masked = n_raw & mask_q[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.read_data  <= rd;
			result_s2.tx_valid   <= txv;
			result_s2.tx_word    <= txw;
			result_s2.irq_status <= n_masked;
			result_s2.error      <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_count_q <= '0;
			rx_count_q <= '0;
			tx_head_q  <= '0;
			rx_head_q  <= '0;
			busy_q     <= 1'b0;
			pend_q     <= 1'b0;
			en_q       <= 1'b0;
			mask_q     <= '0;
			raw_q      <= RAW_RESET;
			masked_q   <= '0;
		end else if (advance) begin
			tx_count_q <= n_tx_count;
			rx_count_q <= n_rx_count;
			tx_head_q  <= n_tx_head;
			rx_head_q  <= n_rx_head;
			busy_q     <= n_busy;
			pend_q     <= n_pend;
			en_q       <= n_en;
			mask_q     <= n_mask;
			raw_q      <= n_raw;
			masked_q   <= n_masked;
		end
	end

	// fifo storage, no reset: entries are read only after being written
	always_ff @(posedge clk) begin
		if (advance && tx_we) begin
			tx_mem_q[tx_widx] <= item_s1.word;
		end
		if (advance && rx_we) begin
			rx_mem_q[rx_widx] <= item_s1.word;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus reads and writes, transmit ticks and reception events into the
// SPI controller register block, predicts every result from a model of the
// FIFOs, status and interrupt flags, and checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;
	import spic_pkg::*;

	localparam int DEPTH        = 8;
	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 10;

	typedef struct {
		item_t it;
		int    ph;
		bit    hold;
	} stim_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b1;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	stim_t   pending_items[$];
	result_t expected_results[$];

	// controller state as the predictor sees it
	logic [15:0] tx_fifo [DEPTH];
	logic [15:0] rx_fifo [DEPTH];
	logic [3:0]  tx_level = '0;
	logic [3:0]  rx_level = '0;
	logic [2:0]  tx_rd = '0;
	logic [2:0]  rx_rd = '0;
	logic        busy = 1'b0;
	logic        xfer_pending = 1'b0;
	logic        serial_en = 1'b0;
	logic [15:0] irq_mask = '0;
	logic [3:0]  raw_flags = RAW_RESET;
	logic [3:0]  masked_flags = '0;

	int fail_count = 0;
	int cycle_count = 0;
	int idle_phase = 0;
	int fill_phase = 0;
	int last_phase = 0;
	int n_random = 0;

	spi_controller_fifo_regs dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void update_irq();
		raw_flags[3] = (tx_level <= DEPTH / 2);
		raw_flags[2] = (rx_level >= DEPTH / 2);
		masked_flags = raw_flags & irq_mask[3:0];
	endfunction

	function automatic result_t predict_spi(item_t it);
		result_t r;
		r = '0;
		case (it.op)
			OP_READ: begin
				if (it.reg_offset == OFS_DATA) begin
					if (rx_level == 0) begin
						r.error = ERR_RX_UNDERFLOW;
					end else begin
						r.read_data = rx_fifo[rx_rd];
						rx_rd = rx_rd + 3'd1;
						rx_level = rx_level - 4'd1;
						update_irq();
					end
				end else if (it.reg_offset == OFS_STATUS) begin
					r.read_data = {11'b0, busy, rx_level == DEPTH, rx_level != 0,
						tx_level != DEPTH, tx_level == 0};
				end else if (it.reg_offset == OFS_RAW) begin
					r.read_data = {12'b0, raw_flags};
				end else begin
					r.error = ERR_UNMAPPED;
				end
			end
			OP_WRITE: begin
				if (it.reg_offset == OFS_CTRL0 || it.reg_offset == OFS_DMA) begin
					// accepted, no effect
				end else if (it.reg_offset == OFS_CTRL1) begin
					serial_en = it.word[1];
					if (serial_en && !busy && tx_level != 0) begin
						busy = 1'b1;
						xfer_pending = 1'b1;
					end
				end else if (it.reg_offset == OFS_DATA) begin
					if (tx_level >= DEPTH) begin
						r.error = ERR_TX_OVERFLOW;
					end else begin
						tx_fifo[tx_rd + tx_level[2:0]] = it.word;
						tx_level = tx_level + 4'd1;
						update_irq();
						if (serial_en) begin
							busy = 1'b1;
							xfer_pending = 1'b1;
						end
					end
				end else if (it.reg_offset == OFS_MASK) begin
					// mask takes effect on the next fifo change only
					irq_mask = it.word;
				end else if (it.reg_offset == OFS_CLEAR) begin
					raw_flags = raw_flags & ~CLEAR_BITS;
					masked_flags = masked_flags & ~CLEAR_BITS;
				end else begin
					r.error = ERR_UNMAPPED;
				end
			end
			OP_TICK: begin
				if (xfer_pending && serial_en && tx_level != 0) begin
					r.tx_valid = 1'b1;
					r.tx_word = tx_fifo[tx_rd];
					tx_rd = tx_rd + 3'd1;
					tx_level = tx_level - 4'd1;
					if (tx_level == 0) begin
						xfer_pending = 1'b0;
						busy = 1'b0;
					end
					update_irq();
				end
			end
			OP_RX_WORD: begin
				if (!serial_en) begin
					r.error = ERR_BAD_EVENT;
				end else if (rx_level >= DEPTH) begin
					r.error = ERR_RX_OVERFLOW;
				end else begin
					rx_fifo[rx_rd + rx_level[2:0]] = it.word;
					rx_level = rx_level + 4'd1;
					update_irq();
				end
			end
			OP_RX_START: begin
				if (rx_level >= DEPTH || !serial_en || busy)
					r.error = ERR_BAD_EVENT;
				else
					busy = 1'b1;
			end
			OP_RX_END: begin
				if (!serial_en || !busy) begin
					r.error = ERR_BAD_EVENT;
				end else begin
					busy = 1'b0;
					if (tx_level != 0) begin
						busy = 1'b1;
						xfer_pending = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.irq_status = masked_flags;
		return r;
	endfunction

	// the first item of each later fill phase waits until the block has drained
	task automatic add_item(op_t op, logic [11:0] ofs, logic [15:0] w);
		stim_t s;
		s.it.op = op;
		s.it.reg_offset = ofs;
		s.it.word = w;
		s.ph = fill_phase;
		s.hold = (fill_phase != last_phase);
		last_phase = fill_phase;
		pending_items.push_back(s);
	endtask

	function automatic logic [11:0] any_offset();
		logic [11:0] mapped [8];
		mapped = '{OFS_CTRL0, OFS_CTRL1, OFS_DATA, OFS_STATUS,
			OFS_MASK, OFS_RAW, OFS_CLEAR, OFS_DMA};
		if ($urandom_range(1, 0) == 0)
			return mapped[$urandom_range(7, 0)];
		return 12'($urandom_range(4095, 0));
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				expected_results.push_back(predict_spi(item));
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0
						&& !(pending_items[0].hold && expected_results.size() != 0)
						&& $urandom_range(99, 0) >= (pending_items[0].ph == 0 ? 7 :
							pending_items[0].ph == 1 ? 81 : 0)) begin
					item <= pending_items[0].it;
					item_valid <= 1'b1;
					idle_phase <= pending_items[0].ph;
					void'(pending_items.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: %p", result);
					fail_count++;
				end else begin
					if (result.read_data !== expected_results[0].read_data
							|| result.tx_valid !== expected_results[0].tx_valid
							|| result.tx_word !== expected_results[0].tx_word
							|| result.irq_status !== expected_results[0].irq_status
							|| result.error !== expected_results[0].error) begin
						if (fail_count < 10)
							$display("mismatch: expected %p, got %p",
								expected_results[0], result);
						fail_count++;
					end
					void'(expected_results.pop_front());
				end
			end
			result_stall <= ($urandom_range(99, 0) < (idle_phase == 0 ? 81 :
				idle_phase == 1 ? 7 : 0));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		int kind;
		int n;

		// directed: reset state, unmapped access, disabled events, transfer,
		// reception and interrupt clear
		add_item(OP_READ, OFS_STATUS, 16'h0000);
		add_item(OP_READ, OFS_RAW, 16'h0000);
		add_item(OP_READ, OFS_DATA, 16'h0000);
		add_item(OP_READ, OFS_CTRL0, 16'h0000);
		add_item(OP_READ, 12'hFFF, 16'hFFFF);
		add_item(OP_WRITE, 12'hFFF, 16'hFFFF);
		add_item(OP_WRITE, 12'h002, 16'h1234);
		add_item(OP_RX_WORD, OFS_CTRL0, 16'hFFFF);
		add_item(OP_RX_START, OFS_CTRL0, 16'h0000);
		add_item(OP_RX_END, OFS_CTRL0, 16'h0000);
		add_item(OP_WRITE, OFS_DATA, 16'hFFFF);
		add_item(OP_TICK, OFS_CTRL0, 16'h0000);
		add_item(OP_WRITE, OFS_MASK, 16'hFFFF);
		add_item(OP_WRITE, OFS_CTRL1, 16'hFFFF);
		add_item(OP_TICK, OFS_CTRL0, 16'h0000);
		add_item(OP_TICK, OFS_CTRL0, 16'h0000);
		add_item(OP_WRITE, OFS_CTRL0, 16'hFFFF);
		add_item(OP_WRITE, OFS_DMA, 16'h0000);
		add_item(OP_RX_END, OFS_CTRL0, 16'h0000);
		add_item(OP_RX_START, OFS_CTRL0, 16'h0000);
		add_item(OP_RX_START, OFS_CTRL0, 16'h0000);
		add_item(OP_RX_WORD, OFS_CTRL0, 16'hFFFF);
		add_item(OP_RX_END, OFS_CTRL0, 16'h0000);
		add_item(OP_READ, OFS_DATA, 16'h0000);
		add_item(OP_WRITE, OFS_CLEAR, 16'hFFFF);
		add_item(OP_READ, OFS_RAW, 16'h0000);
		add_item(OP_WRITE, OFS_CTRL1, 16'h0000);

		while (n_random < RANDOM_ITEMS) begin
			fill_phase = n_random * 3 / RANDOM_ITEMS;
			kind = $urandom_range(99, 0);
			if (kind < 25) begin
				// transmit burst, then ticks to drain it
				if ($urandom_range(9, 0) < 7)
					add_item(OP_WRITE, OFS_CTRL1, 16'($urandom) | 16'h0002);
				n = $urandom_range(10, 1);
				repeat (n) add_item(OP_WRITE, OFS_DATA, 16'($urandom));
				n_random += n;
				n = $urandom_range(10, 0);
				repeat (n) add_item(OP_TICK, 12'($urandom), 16'($urandom));
				n_random += n;
			end else if (kind < 50) begin
				// reception: start, words, end, then drain by reads
				add_item(OP_RX_START, 12'($urandom), 16'($urandom));
				n = $urandom_range(10, 1);
				repeat (n) add_item(OP_RX_WORD, 12'($urandom), 16'($urandom));
				add_item(OP_RX_END, 12'($urandom), 16'($urandom));
				n_random += n + 2;
				n = $urandom_range(10, 0);
				repeat (n) add_item(OP_READ, OFS_DATA, 16'($urandom));
				n_random += n;
			end else if (kind < 65) begin
				if ($urandom_range(9, 0) < 8)
					add_item(OP_WRITE, OFS_CTRL1, 16'($urandom) | 16'h0002);
				else
					add_item(OP_WRITE, OFS_CTRL1, 16'($urandom) & ~16'h0002);
				n_random++;
			end else if (kind < 75) begin
				if ($urandom_range(1, 0) == 0)
					add_item(OP_WRITE, OFS_MASK, 16'($urandom));
				else
					add_item(OP_WRITE, OFS_CLEAR, 16'($urandom));
				n_random++;
			end else if (kind < 85) begin
				add_item(OP_READ, $urandom_range(1, 0) ? OFS_STATUS : OFS_RAW,
					16'($urandom));
				n_random++;
			end else begin
				add_item(op_t'($urandom_range(5, 0)), any_offset(), 16'($urandom));
				n_random++;
			end
		end

		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// drive reset low at time zero so the falling edge is seen
	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

endmodule
